// ===== sv/tfa_pkg.sv =====
`timescale 1ns / 1ps
package tfa_pkg;
    localparam int MaxSeatsDefault = 8;
    localparam int TicketBitsDefault = 32;

    typedef enum logic [1:0] {
        K_REQUEST = 2'd0,
        K_RELEASE = 2'd1,
        K_LEAVE   = 2'd2,
        K_DROP    = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVENT,
        S_SCAN,
        S_GRANT,
        S_OUT
    } t_state;
endpackage

// ===== sv/ticket_fair_ring_fork_arbiter_unit.sv =====
`timescale 1ns / 1ps
// From the accepting edge to the final result, n the ring size: a decode step (S_EVENT), a scan
// (S_SCAN) reading each of the n tickets once, then per round a compare of each seat (S_GRANT)
// and an output step (S_OUT). A grant is held one round so its last flag is known. Output
// stalls hold the output step until the result is taken.
// One event at a time; the next request is taken only after the final result has been issued.
// Reset (i_rst_n low, synchronous): ring size 8, seats active and idle, resources free, ticket
// counter zero; the ticket memory is not cleared, a ticket is ignored until its seat requests.
module ticket_fair_ring_fork_arbiter_unit #(
    parameter int MAX_SEATS   = tfa_pkg::MaxSeatsDefault,
    parameter int TICKET_BITS = tfa_pkg::TicketBitsDefault
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [3:0] i_cfg_data,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // seat[2:0], zero fill
    input  logic [1:0] s_axis_tuser,   // kind[1:0]
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // granted_seat[2:0], zero fill
    output logic       m_axis_tuser,   // grant_valid[0]
    output logic       m_axis_tlast
);
    import tfa_pkg::*;

    localparam int SW = $clog2(MAX_SEATS);
    localparam int NW = $clog2(MAX_SEATS + 1);

    t_state              r_state, n_state;
    logic [3:0]          r_cfg;
    logic [MAX_SEATS-1:0] r_hungry, r_active, r_taken;
    logic [SW-1:0]       r_owner [MAX_SEATS];
    logic [TICKET_BITS-1:0] r_counter;
    t_kind               r_kind;
    logic [2:0]          r_seat;
    logic [SW-1:0]       r_idx;      // read address being issued
    logic                r_rd_vld;   // data for r_rd_seat valid this cycle
    logic [SW-1:0]       r_rd_seat;
    logic [TICKET_BITS-1:0] r_tk [MAX_SEATS];  // snapshot of tickets for the event
    logic                r_found;
    logic [SW-1:0]       r_best;
    logic [TICKET_BITS-1:0] r_best_tk;
    logic [SW-1:0]       r_gidx;     // seat compared this cycle
    logic                r_any;      // a grant is held in r_hold
    logic [2:0]          r_hold;
    logic [NW-1:0]       r_pending;  // reads left to issue
    logic                r_ovld, r_olast;
    logic [2:0]          r_oseat;
    logic                r_ogv;

    logic [NW-1:0]       w_n;
    logic [TICKET_BITS-1:0] w_rdata;
    logic                w_we;
    logic [SW-1:0]       w_s;
    logic                w_in_ring;
    logic                w_emit;

    always_comb begin
        if (r_cfg < 4'd2) w_n = NW'(2);
        else if (32'(r_cfg) > MAX_SEATS) w_n = NW'(MAX_SEATS);
        else w_n = NW'(r_cfg);
    end

    assign w_s       = SW'(r_seat);
    assign w_in_ring = (32'(r_seat) < 32'(w_n)) && r_active[w_s];
    assign w_we      = (r_state == S_EVENT) && w_in_ring && (r_kind == K_REQUEST);

    tfa_ticket_mem #(.Depth(MAX_SEATS), .Width(TICKET_BITS)) u_mem (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_s),
        .i_wdata(r_counter + TICKET_BITS'(1)),
        .i_raddr(r_idx),
        .o_rdata(w_rdata)
    );

    function automatic logic [SW-1:0] nxt(input logic [SW-1:0] i, input logic [NW-1:0] n);
        nxt = (32'(i) + 1 >= 32'(n)) ? '0 : SW'(32'(i) + 1);
    endfunction
    function automatic logic [SW-1:0] prv(input logic [SW-1:0] i, input logic [NW-1:0] n);
        prv = (i == '0) ? SW'(32'(n) - 1) : SW'(32'(i) - 1);
    endfunction

    // A seat qualifies when hungry, both resources free and no hungry neighbor
    // holds an earlier ticket.
    logic [SW-1:0] w_c_l, w_c_r;
    logic [MAX_SEATS-1:0] w_ok;
    always_comb begin
        for (int i = 0; i < MAX_SEATS; i++) begin
            w_c_l = prv(SW'(i), w_n);
            w_c_r = nxt(SW'(i), w_n);
            w_ok[i] = (i < 32'(w_n)) && r_hungry[i] && !r_taken[i] && !r_taken[w_c_r]
                && !(r_hungry[w_c_l] && r_tk[w_c_l] < r_tk[i])
                && !(r_hungry[w_c_r] && r_tk[w_c_r] < r_tk[i]);
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = (r_state == S_IDLE) && !r_ovld;
    assign m_axis_tvalid = r_ovld;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tdata  = {5'd0, r_oseat};
    assign m_axis_tuser  = r_ogv;

    // a result leaves once the next round decides: held grant, or no grant at all
    assign w_emit = (r_state == S_OUT) && (!r_ovld || m_axis_tready) && (r_any || !r_found);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (s_axis_tvalid) n_state = S_EVENT;
            S_EVENT: n_state = S_SCAN;
            S_SCAN:  if (!r_rd_vld && r_pending == '0) n_state = S_GRANT;
            S_GRANT: if (32'(r_gidx) + 1 >= 32'(w_n)) n_state = S_OUT;
            S_OUT:   if (!r_ovld || m_axis_tready) n_state = r_found ? S_GRANT : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cfg     <= 4'd8;
            r_hungry  <= '0;
            r_active  <= '1;
            r_taken   <= '0;
            r_counter <= '0;
            r_ovld    <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_pending <= '0;
            r_idx     <= '0;
            r_gidx    <= '0;
            r_any     <= 1'b0;
            r_found   <= 1'b0;
            for (int i = 0; i < MAX_SEATS; i++) r_owner[i] <= '0;
        end else begin
            r_state <= n_state;
            if (w_emit) r_ovld <= 1'b1;
            else if (m_axis_tready) r_ovld <= 1'b0;
            r_rd_vld <= (r_state == S_SCAN) && (r_pending != '0);
            unique case (r_state)
                S_IDLE: begin
                    if (i_cfg_valid && !r_ovld) r_cfg <= i_cfg_data;
                    if (s_axis_tvalid) begin
                        r_kind <= t_kind'(s_axis_tuser);
                        r_seat <= s_axis_tdata[2:0];
                    end
                    r_any <= 1'b0;
                end
                S_EVENT: begin
                    if (w_in_ring) begin
                        unique case (r_kind)
                            K_REQUEST: begin
                                r_counter <= r_counter + TICKET_BITS'(1);
                                r_hungry[w_s] <= 1'b1;
                            end
                            K_RELEASE: begin
                                if (r_owner[w_s] == w_s) r_taken[w_s] <= 1'b0;
                                if (r_owner[nxt(w_s, w_n)] == w_s)
                                    r_taken[nxt(w_s, w_n)] <= 1'b0;
                            end
                            K_LEAVE: begin
                                r_active[w_s] <= 1'b0;
                                r_hungry[w_s] <= 1'b0;
                            end
                            default: begin
                                r_active[w_s] <= 1'b0;
                                r_hungry[w_s] <= 1'b0;
                                if (r_owner[w_s] == w_s) r_taken[w_s] <= 1'b0;
                                if (r_owner[nxt(w_s, w_n)] == w_s)
                                    r_taken[nxt(w_s, w_n)] <= 1'b0;
                            end
                        endcase
                    end
                    r_idx     <= '0;
                    r_pending <= w_n;
                end
                S_SCAN: begin
                    if (r_rd_vld) r_tk[r_rd_seat] <= w_rdata;
                    if (r_pending != '0) begin
                        r_rd_seat <= r_idx;
                        r_idx     <= nxt(r_idx, w_n);
                        r_pending <= (r_idx == SW'(32'(w_n) - 1)) ? '0 : r_pending - NW'(1);
                    end
                    r_gidx  <= '0;
                    r_found <= 1'b0;
                end
                S_GRANT: begin
                    // strict compare keeps the lowest seat on equal tickets
                    if (w_ok[r_gidx] && (!r_found || r_tk[r_gidx] < r_best_tk)) begin
                        r_found   <= 1'b1;
                        r_best    <= r_gidx;
                        r_best_tk <= r_tk[r_gidx];
                    end
                    r_gidx <= r_gidx + SW'(1);
                end
                S_OUT: begin
                    if (!r_ovld || m_axis_tready) begin
                        if (r_any) begin
                            r_ogv   <= 1'b1;
                            r_oseat <= r_hold;
                            r_olast <= !r_found;
                        end else if (!r_found) begin
                            r_ogv   <= 1'b0;
                            r_oseat <= 3'd0;
                            r_olast <= 1'b1;
                        end
                        r_gidx  <= '0;
                        r_found <= 1'b0;
                        if (r_found) begin
                            r_taken[r_best] <= 1'b1;
                            r_owner[r_best] <= r_best;
                            r_taken[nxt(r_best, w_n)] <= 1'b1;
                            r_owner[nxt(r_best, w_n)] <= r_best;
                            r_hungry[r_best] <= 1'b0;
                            r_hold  <= 3'(r_best);
                            r_any   <= 1'b1;
                        end else begin
                            r_any   <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    logic w_unused;
    assign w_unused = ^s_axis_tdata[7:3];

    a_grant_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_found && (!r_ovld || m_axis_tready)) |->
        (!r_taken[r_best] && !r_taken[nxt(r_best, w_n)]))
        else $error("grant of a taken resource");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_axis_tready)
        else $error("input taken while busy");
    a_ring_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_n >= NW'(2)) && (32'(w_n) <= MAX_SEATS))
        else $error("ring size out of range");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable({m_axis_tuser, m_axis_tdata, m_axis_tlast})))
        else $error("result changed while stalled");
endmodule

// ===== sv/tfa_ticket_mem.sv =====
`timescale 1ns / 1ps
// Ticket store: one synchronous memory, one write port, one registered read port.
module tfa_ticket_mem #(
    parameter int Depth = 8,
    parameter int Width = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import tfa_pkg::*;

    typedef struct packed {
        t_kind      kind;
        logic [2:0] seat;
    } t_event;

    typedef struct packed {
        logic       grant_valid;
        logic [2:0] granted_seat;
        logic       last;
    } t_grant;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [3:0] i_cfg_data = 4'd0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'd0;
    logic [1:0] s_axis_tuser = 2'd0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tuser;
    logic       m_axis_tlast;

    ticket_fair_ring_fork_arbiter_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // arbiter shadow state
    logic [3:0]  ring_reg;
    logic [7:0]  hungry, active, taken;
    logic [2:0]  owner [8];
    logic [31:0] ticket [8];
    logic [31:0] ticket_ctr;

    t_event event_q[$];
    t_grant grant_q[$];
    int     errors = 0;
    int     events_sent = 0;
    int     grants_seen = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    int     hold_id = 0;
    int     hold_seen = 0;
    int     hold_cnt = 0;
    int     quiet_cycles = 0;

    function automatic int ring_n();
        if (ring_reg < 2) return 2;
        if (ring_reg > 8) return 8;
        return ring_reg;
    endfunction

    function automatic void free_owned(int s, int n);
        int r1;
        r1 = (s + 1) % n;
        if (taken[s] && owner[s] == s) taken[s] = 1'b0;
        if (taken[r1] && owner[r1] == s) taken[r1] = 1'b0;
    endfunction

    function automatic void predict_grants(t_event ev);
        int n, s, cnt, best, ln, rn;
        bit found;
        logic [31:0] bt;
        t_grant g;
        n = ring_n();
        s = ev.seat;
        cnt = 0;
        if (s < n && active[s]) begin
            case (ev.kind)
                K_REQUEST: begin
                    ticket_ctr = ticket_ctr + 1;
                    ticket[s] = ticket_ctr;
                    hungry[s] = 1'b1;
                end
                K_RELEASE: free_owned(s, n);
                K_LEAVE: begin
                    active[s] = 1'b0;
                    hungry[s] = 1'b0;
                end
                default: begin
                    active[s] = 1'b0;
                    hungry[s] = 1'b0;
                    free_owned(s, n);
                end
            endcase
        end
        forever begin
            found = 1'b0;
            best = 0;
            bt = '0;
            for (int i = 0; i < n; i++) begin
                ln = (i + n - 1) % n;
                rn = (i + 1) % n;
                if (!hungry[i] || taken[i] || taken[rn]) continue;
                if (hungry[ln] && ticket[ln] < ticket[i]) continue;
                if (hungry[rn] && ticket[rn] < ticket[i]) continue;
                if (!found || ticket[i] < bt) begin
                    found = 1'b1;
                    best = i;
                    bt = ticket[i];
                end
            end
            if (!found) break;
            taken[best] = 1'b1;
            owner[best] = 3'(best);
            taken[(best + 1) % n] = 1'b1;
            owner[(best + 1) % n] = 3'(best);
            hungry[best] = 1'b0;
            g.grant_valid = 1'b1;
            g.granted_seat = 3'(best);
            g.last = 1'b0;
            grant_q.push_back(g);
            cnt++;
        end
        if (cnt == 0) begin
            g = '{1'b0, 3'd0, 1'b1};
            grant_q.push_back(g);
        end else begin
            g = grant_q.pop_back();
            g.last = 1'b1;
            grant_q.push_back(g);
        end
    endfunction

    // driver
    always @(posedge i_clk) begin
        t_event ev;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_grants(t_event'({s_axis_tuser, s_axis_tdata[2:0]}));
                events_sent++;
            end
            if ((!s_axis_tvalid || s_axis_tready) ) begin
                if (event_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    ev = event_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {5'b0, ev.seat};
                    s_axis_tuser <= ev.kind;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver hold-off: runs its own cycle count once requested
    always @(posedge i_clk) begin
        if (hold_id != hold_seen) begin
            hold_seen <= hold_id;
            hold_cnt <= 400;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_grant exp_g;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                grants_seen++;
                if (grant_q.size() == 0) begin
                    $error("result with none expected: data %h last %b",
                           m_axis_tdata, m_axis_tlast);
                    errors++;
                end else begin
                    exp_g = grant_q.pop_front();
                    if (m_axis_tuser !== exp_g.grant_valid) begin
                        $error("grant_valid: expected %0d actual %0d",
                               exp_g.grant_valid, m_axis_tuser);
                        errors++;
                    end
                    if (m_axis_tdata[2:0] !== exp_g.granted_seat) begin
                        $error("granted_seat: expected %0d actual %0d",
                               exp_g.granted_seat, m_axis_tdata[2:0]);
                        errors++;
                    end
                    if (m_axis_tlast !== exp_g.last) begin
                        $error("last: expected %0d actual %0d", exp_g.last, m_axis_tlast);
                        errors++;
                    end
                    if (m_axis_tdata[7:3] !== 5'd0) begin
                        $error("fill: expected 0 actual %h", m_axis_tdata[7:3]);
                        errors++;
                    end
                end
            end
            m_axis_tready <= (hold_cnt == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic drain();
        while (event_q.size() > 0 || s_axis_tvalid || grant_q.size() > 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_ring(input logic [3:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        ring_reg = val;
    endtask

    // lawful-looking traffic: mostly requests and releases, some leave/drop
    task automatic queue_random(input int count, input int seat_max);
        t_event ev;
        int r;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(99);
            ev.kind = r < 50 ? K_REQUEST : r < 88 ? K_RELEASE : r < 94 ? K_LEAVE : K_DROP;
            ev.seat = $urandom_range(seat_max);
            event_q.push_back(ev);
        end
    endtask

    task automatic reset_dut();
        ring_reg = 4'd8;
        hungry = '0;
        active = '1;
        taken = '0;
        ticket_ctr = '0;
        for (int i = 0; i < 8; i++) begin
            owner[i] = '0;
            ticket[i] = '0;
        end
        i_rst_n <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
    endtask

    initial begin
        reset_dut();

        // directed: neighbours compete, eat, release, leave/drop and inactive seats
        for (int s = 0; s < 8; s++) event_q.push_back('{K_REQUEST, 3'(s)});
        event_q.push_back('{K_REQUEST, 3'd0});   // request while eating
        event_q.push_back('{K_RELEASE, 3'd3});   // release not owned
        for (int s = 0; s < 8; s += 2) event_q.push_back('{K_RELEASE, 3'(s)});
        event_q.push_back('{K_LEAVE, 3'd7});
        event_q.push_back('{K_REQUEST, 3'd7});   // inactive seat ignored
        event_q.push_back('{K_DROP, 3'd1});
        event_q.push_back('{K_RELEASE, 3'd5});
        event_q.push_back('{K_DROP, 3'd6});
        drain();

        // small ring: seat beyond ring ignored
        write_ring(4'd2);
        event_q.push_back('{K_REQUEST, 3'd0});
        event_q.push_back('{K_REQUEST, 3'd7});
        event_q.push_back('{K_RELEASE, 3'd0});
        queue_random(60, 3);
        drain();

        // clamp cases, then pressure: receiver holds off while sender keeps going
        write_ring(4'd0);
        queue_random(20, 2);
        drain();
        write_ring(4'd15);
        hold_id++;
        queue_random(30, 7);
        wait (hold_cnt > 0);
        wait (hold_cnt == 0);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 68 : 25) : 0;
            recv_stall_pct = (ph == 2) ? 68 : (ph == 3 ? 25 : 0);
            write_ring(4'($urandom_range(2, 8)));
            queue_random(75, $urandom_range(2, 7));
            drain();
        end

        $display("Ran %0d events, checked %0d results over rings of 2..8 seats",
                 events_sent, grants_seen);
        $display("with idle/stall phases and a long output hold-off.");
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
sv/tfa_pkg.sv
sv/tfa_ticket_mem.sv
sv/ticket_fair_ring_fork_arbiter_unit.sv
tb/sv/tb_top.sv
